/* hw/rtl/pfa_pkg.sv */
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, constants, micro-op table and helpers for the pair force accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

    localparam int MAX_PARTICLES = 1024;
    localparam int ADDR_W        = $clog2(MAX_PARTICLES);
    localparam int IDX_W         = 10;
    localparam int Q_W           = 48;   // Q24.24 word
    localparam int SUM_W         = 51;   // exact sum of up to four Q24.24 terms
    localparam int ROOT_W        = 28;   // sqrt of a 56-bit radicand
    localparam int NUM_W         = 56;   // divider dividend
    localparam int PC_W          = 5;

    // configuration register indexes
    localparam logic [2:0] CFG_FORCE_LAW   = 3'd0;
    localparam logic [2:0] CFG_COEF_FIRST  = 3'd1;
    localparam logic [2:0] CFG_COEF_SECOND = 3'd2;
    localparam logic [2:0] CFG_COEF_THIRD  = 3'd3;
    localparam logic [2:0] CFG_CUTOFF_SQ   = 3'd4;

    // force laws
    localparam logic [2:0] LAW_WCA      = 3'd0;
    localparam logic [2:0] LAW_QUARTIC  = 3'd1;
    localparam logic [2:0] LAW_CUBIC    = 3'd2;
    localparam logic [2:0] LAW_INV_HARM = 3'd3;
    localparam logic [2:0] LAW_HARMONIC = 3'd4;
    localparam logic [2:0] LAW_CONSTANT = 3'd5;

    // operations and result status
    localparam logic OP_APPLY = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [1:0] ST_APPLIED = 2'd0;
    localparam logic [1:0] ST_SKIPPED = 2'd1;
    localparam logic [1:0] ST_READOUT = 2'd2;

    // micro-op kinds
    localparam logic [2:0] K_SQRT   = 3'd0;
    localparam logic [2:0] K_MUL    = 3'd1;
    localparam logic [2:0] K_DIV    = 3'd2;
    localparam logic [2:0] K_ADDC1  = 3'd3;
    localparam logic [2:0] K_BRANCH = 3'd4;
    localparam logic [2:0] K_TAIL   = 3'd5;
    localparam logic [2:0] K_END    = 3'd6;

    // operand selects
    localparam logic [3:0] SEL_T0 = 4'd0;
    localparam logic [3:0] SEL_T1 = 4'd1;
    localparam logic [3:0] SEL_T2 = 4'd2;
    localparam logic [3:0] SEL_R  = 4'd3;
    localparam logic [3:0] SEL_D2 = 4'd4;
    localparam logic [3:0] SEL_C1 = 4'd5;
    localparam logic [3:0] SEL_C2 = 4'd6;
    localparam logic [3:0] SEL_C3 = 4'd7;
    localparam logic [3:0] SEL_F  = 4'd8;

    // destinations
    localparam logic [2:0] DST_T0  = 3'd0;
    localparam logic [2:0] DST_T1  = 3'd1;
    localparam logic [2:0] DST_T2  = 3'd2;
    localparam logic [2:0] DST_SUM = 3'd3;
    localparam logic [2:0] DST_FX  = 3'd4;
    localparam logic [2:0] DST_FY  = 3'd5;

    // divider dividend selects
    localparam logic [1:0] NUM_ONE = 2'd0;
    localparam logic [1:0] NUM_DX  = 2'd1;
    localparam logic [1:0] NUM_DY  = 2'd2;

    // accumulator memory commands
    localparam logic [2:0] MEM_NONE     = 3'd0;
    localparam logic [2:0] MEM_RD_J     = 3'd1;
    localparam logic [2:0] MEM_RD_K     = 3'd2;
    localparam logic [2:0] MEM_WR_J_ADD = 3'd3;
    localparam logic [2:0] MEM_WR_K_SUB = 3'd4;
    localparam logic [2:0] MEM_WR_J_ZRO = 3'd5;
    localparam logic [2:0] MEM_CLR      = 3'd6;

    // program addresses
    localparam logic [PC_W-1:0] PC_WCA  = 5'd2;
    localparam logic [PC_W-1:0] PC_POLY = 5'd11;
    localparam logic [PC_W-1:0] PC_INVH = 5'd16;
    localparam logic [PC_W-1:0] PC_HARM = 5'd18;
    localparam logic [PC_W-1:0] PC_CONS = 5'd21;
    localparam logic [PC_W-1:0] PC_TAIL = 5'd23;

    typedef struct packed {
        logic                    operation;
        logic signed [31:0]      delta_x;
        logic signed [31:0]      delta_y;
        logic [31:0]             dist_sq;
        logic [IDX_W-1:0]        first_index;
        logic [IDX_W-1:0]        second_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [Q_W-1:0]   force_x;
        logic signed [Q_W-1:0]   force_y;
    } out_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] a_sel;
        logic [3:0] b_sel;
        logic [2:0] dst;
        logic [1:0] num_sel;
    } uop_t;

    typedef struct packed {
        logic              load;
        logic              start;
        uop_t              uop;
        logic [2:0]        mem_cmd;
        logic [ADDR_W-1:0] clr_addr;
        logic              emit;
        logic [1:0]        emit_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       is_read;
        logic       skip;
        logic [2:0] law;
        logic       unit_done;
    } dp_status_t;

    function automatic uop_t mk(input logic [2:0] kind, input logic [3:0] a,
                                input logic [3:0] b, input logic [2:0] d,
                                input logic [1:0] n);
        uop_t u;
        u.kind    = kind;
        u.a_sel   = a;
        u.b_sel   = b;
        u.dst     = d;
        u.num_sel = n;
        return u;
    endfunction

    function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            5'd0:  u = mk(K_SQRT,   SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            5'd1:  u = mk(K_BRANCH, SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            // WCA: p = 1/r, then p^2, p^3, p^6, p^7, p^13
            5'd2:  u = mk(K_DIV,    SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            5'd3:  u = mk(K_MUL,    SEL_T0, SEL_T0, DST_T1,  NUM_ONE);
            5'd4:  u = mk(K_MUL,    SEL_T1, SEL_T0, DST_T1,  NUM_ONE);
            5'd5:  u = mk(K_MUL,    SEL_T1, SEL_T1, DST_T1,  NUM_ONE);
            5'd6:  u = mk(K_MUL,    SEL_T1, SEL_T0, DST_T2,  NUM_ONE);
            5'd7:  u = mk(K_MUL,    SEL_T2, SEL_T1, DST_T1,  NUM_ONE);
            5'd8:  u = mk(K_MUL,    SEL_C1, SEL_T1, DST_SUM, NUM_ONE);
            5'd9:  u = mk(K_MUL,    SEL_C2, SEL_T2, DST_SUM, NUM_ONE);
            5'd10: u = mk(K_TAIL,   SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            // polynomial
            5'd11: u = mk(K_MUL,    SEL_D2, SEL_R,  DST_T1,  NUM_ONE);
            5'd12: u = mk(K_MUL,    SEL_C3, SEL_T1, DST_SUM, NUM_ONE);
            5'd13: u = mk(K_MUL,    SEL_C2, SEL_D2, DST_SUM, NUM_ONE);
            5'd14: u = mk(K_MUL,    SEL_C1, SEL_R,  DST_SUM, NUM_ONE);
            5'd15: u = mk(K_TAIL,   SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            // inverse harmonic
            5'd16: u = mk(K_MUL,    SEL_C1, SEL_R,  DST_SUM, NUM_ONE);
            5'd17: u = mk(K_TAIL,   SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            // harmonic
            5'd18: u = mk(K_ADDC1,  SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            5'd19: u = mk(K_MUL,    SEL_C2, SEL_R,  DST_SUM, NUM_ONE);
            5'd20: u = mk(K_TAIL,   SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            // constant
            5'd21: u = mk(K_ADDC1,  SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            5'd22: u = mk(K_TAIL,   SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
            // projection
            5'd23: u = mk(K_DIV,    SEL_T0, SEL_T0, DST_T0,  NUM_DX);
            5'd24: u = mk(K_DIV,    SEL_T0, SEL_T0, DST_T1,  NUM_DY);
            5'd25: u = mk(K_MUL,    SEL_F,  SEL_T0, DST_FX,  NUM_ONE);
            5'd26: u = mk(K_MUL,    SEL_F,  SEL_T1, DST_FY,  NUM_ONE);
            default: u = mk(K_END,  SEL_T0, SEL_T0, DST_T0,  NUM_ONE);
        endcase
        return u;
    endfunction

    function automatic logic [PC_W-1:0] law_pc(input logic [2:0] law);
        logic [PC_W-1:0] pc;
        case (law)
            LAW_WCA:      pc = PC_WCA;
            LAW_QUARTIC:  pc = PC_POLY;
            LAW_CUBIC:    pc = PC_POLY;
            LAW_INV_HARM: pc = PC_INVH;
            LAW_HARMONIC: pc = PC_HARM;
            LAW_CONSTANT: pc = PC_CONS;
            default:      pc = PC_TAIL;   // unused laws: zero force
        endcase
        return pc;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if ((&v[SUM_W-1:Q_W-1]) || !(|v[SUM_W-1:Q_W-1]))
            r = v[Q_W-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(Q_W-1){1'b0}}};
        else
            r = {1'b0, {(Q_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pfa_mul.sv */
// ----------------------------------------------------------------------------
// pfa_mul
// Saturating signed Q24.24 multiplier, four 24x24 partial products in series.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_mul
    import pfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic signed [Q_W-1:0] a,
    input  wire logic signed [Q_W-1:0] b,
    output logic                       done,
    output logic signed [Q_W-1:0]      prod
);

    localparam int H = Q_W / 2;

    logic              busy_reg;
    logic [2:0]        cnt_reg;
    logic              done_reg;
    logic [Q_W-1:0]    ma_reg;
    logic [Q_W-1:0]    mb_reg;
    logic              neg_reg;
    logic [Q_W-1:0]    pr_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic              ovf_reg;
    logic signed [Q_W-1:0] prod_reg;

    logic [Q_W-1:0]    mag_a;
    logic [Q_W-1:0]    mag_b;
    logic [H-1:0]      x;
    logic [H-1:0]      y;
    logic [SUM_W-1:0]  term;
    logic [SUM_W-1:0]  m;
    logic [SUM_W-1:0]  lim;
    logic signed [Q_W-1:0] fin;

    assign mag_a = a[Q_W-1] ? (~a + 1'b1) : a;
    assign mag_b = b[Q_W-1] ? (~b + 1'b1) : b;

    // pair order: lo*lo, hi*lo, lo*hi, hi*hi
    assign x = cnt_reg[0] ? ma_reg[Q_W-1:H] : ma_reg[H-1:0];
    assign y = cnt_reg[1] ? mb_reg[Q_W-1:H] : mb_reg[H-1:0];

    always_comb
    begin
        case (cnt_reg)
            3'd1:    term = {{(SUM_W-H){1'b0}}, pr_reg[Q_W-1:H]};
            3'd2:    term = {{(SUM_W-Q_W){1'b0}}, pr_reg};
            3'd3:    term = {{(SUM_W-Q_W){1'b0}}, pr_reg};
            3'd4:    term = {pr_reg[SUM_W-H-1:0], {H{1'b0}}};
            default: term = '0;
        endcase
    end

    always_comb
    begin
        m = ovf_reg ? (SUM_W'(1) << Q_W) : acc_reg;
        if (neg_reg)
        begin
            lim = SUM_W'(1) << (Q_W - 1);
            fin = (m > lim) ? lim[Q_W-1:0] : (~m[Q_W-1:0] + 1'b1);
            if (m > lim)
                fin = {1'b1, {(Q_W-1){1'b0}}};
        end
        else
        begin
            lim = (SUM_W'(1) << (Q_W - 1)) - 1'b1;
            fin = (m > lim) ? lim[Q_W-1:0] : m[Q_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 3'd5)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg  <= mag_a;
            mb_reg  <= mag_b;
            neg_reg <= a[Q_W-1] ^ b[Q_W-1];
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg < 3'd4)
                pr_reg <= Q_W'(x * y);
            if (cnt_reg != 3'd0 && cnt_reg < 3'd5)
                acc_reg <= acc_reg + term;
            if (cnt_reg == 3'd4)
                ovf_reg <= |pr_reg[Q_W-1:H-1];
            if (cnt_reg == 3'd5)
                prod_reg <= fin;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

/* hw/rtl/pfa_div.sv */
// ----------------------------------------------------------------------------
// pfa_div
// Restoring divider, one quotient bit per cycle, sign applied to the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_div
    import pfa_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [NUM_W-1:0]      num,
    input  wire logic                  neg,
    input  wire logic [ROOT_W-1:0]     den,
    output logic                       done,
    output logic signed [Q_W-1:0]      quo
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  sh_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W-1:0] den_reg;
    logic              neg_reg;

    logic [ROOT_W:0]   rem_sh;
    logic              ge;
    logic [ROOT_W:0]   rem_sub;

    assign rem_sh  = {rem_reg, sh_reg[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
            sh_reg  <= {sh_reg[NUM_W-2:0], ge};
        end
    end

    // quotient stays below 2^44, no clamp needed
    assign quo  = neg_reg ? (~sh_reg[Q_W-1:0] + 1'b1) : sh_reg[Q_W-1:0];
    assign done = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/pfa_datapath.sv */
// ----------------------------------------------------------------------------
// pfa_datapath
// Config registers, item latch, square root, operand routing, multiplier,
// divider, force accumulator memories and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_datapath
    import pfa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_item_t    item,
    input  wire ctrl_cmd_t   cmd,
    input  wire logic        cfg_valid,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [Q_W-1:0] cfg_data,
    output dp_status_t       st,
    output out_item_t        result,
    output logic             done
);

    localparam int SQ_CNT_W = $clog2(ROOT_W);
    localparam logic [SQ_CNT_W-1:0] SQ_LAST = SQ_CNT_W'(ROOT_W - 1);

    // configuration
    logic [2:0]            law_reg;
    logic signed [Q_W-1:0] c1_reg;
    logic signed [Q_W-1:0] c2_reg;
    logic signed [Q_W-1:0] c3_reg;
    logic [31:0]           cut_reg;

    // latched item
    logic                  op_reg;
    logic signed [31:0]    dx_reg;
    logic signed [31:0]    dy_reg;
    logic [31:0]           d2_reg;
    logic [ADDR_W-1:0]     j_reg;
    logic [ADDR_W-1:0]     k_reg;

    // working registers
    uop_t                  uop_reg;
    logic signed [Q_W-1:0] t0_reg;
    logic signed [Q_W-1:0] t1_reg;
    logic signed [Q_W-1:0] t2_reg;
    logic signed [Q_W-1:0] fx_reg;
    logic signed [Q_W-1:0] fy_reg;
    logic signed [SUM_W-1:0] sum_reg;

    // square root
    logic                  sq_busy_reg;
    logic                  sq_done_reg;
    logic [SQ_CNT_W-1:0]   sq_cnt_reg;
    logic [NUM_W-1:0]      sq_n_reg;
    logic [31:0]           sq_rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [31:0]           sq_rem_sh;
    logic [31:0]           sq_trial;
    logic                  sq_ge;

    // memories
    logic [Q_W-1:0]        mem_x [MAX_PARTICLES];
    logic [Q_W-1:0]        mem_y [MAX_PARTICLES];
    logic [Q_W-1:0]        rdx_reg;
    logic [Q_W-1:0]        rdy_reg;
    logic                  re;
    logic                  we;
    logic [ADDR_W-1:0]     raddr;
    logic [ADDR_W-1:0]     waddr;
    logic [Q_W-1:0]        wdx;
    logic [Q_W-1:0]        wdy;

    // units
    logic signed [Q_W-1:0] opa;
    logic signed [Q_W-1:0] opb;
    logic signed [Q_W-1:0] force_f;
    logic                  mul_start;
    logic                  mul_done;
    logic signed [Q_W-1:0] mul_prod;
    logic                  div_start;
    logic                  div_done;
    logic signed [Q_W-1:0] div_quo;
    logic [NUM_W-1:0]      div_num;
    logic                  div_neg;
    logic signed [Q_W-1:0] unit_res;

    out_item_t             result_reg;
    logic                  done_reg;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            law_reg <= LAW_WCA;
            c1_reg  <= '0;
            c2_reg  <= '0;
            c3_reg  <= '0;
            cut_reg <= 32'h0100_0000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FORCE_LAW:   law_reg <= cfg_data[2:0];
                CFG_COEF_FIRST:  c1_reg  <= cfg_data;
                CFG_COEF_SECOND: c2_reg  <= cfg_data;
                CFG_COEF_THIRD:  c3_reg  <= cfg_data;
                CFG_CUTOFF_SQ:   cut_reg <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    assign force_f = sat_q(sum_reg);

    always_comb
    begin
        case (uop_reg.a_sel)
            SEL_T0:  opa = t0_reg;
            SEL_T1:  opa = t1_reg;
            SEL_T2:  opa = t2_reg;
            SEL_R:   opa = {{(Q_W-ROOT_W){1'b0}}, root_reg};
            SEL_D2:  opa = {{(Q_W-32){1'b0}}, d2_reg};
            SEL_C1:  opa = c1_reg;
            SEL_C2:  opa = c2_reg;
            SEL_C3:  opa = c3_reg;
            SEL_F:   opa = force_f;
            default: opa = '0;
        endcase
        case (uop_reg.b_sel)
            SEL_T0:  opb = t0_reg;
            SEL_T1:  opb = t1_reg;
            SEL_T2:  opb = t2_reg;
            SEL_R:   opb = {{(Q_W-ROOT_W){1'b0}}, root_reg};
            SEL_D2:  opb = {{(Q_W-32){1'b0}}, d2_reg};
            SEL_C1:  opb = c1_reg;
            SEL_C2:  opb = c2_reg;
            SEL_C3:  opb = c3_reg;
            SEL_F:   opb = force_f;
            default: opb = '0;
        endcase
    end

    // dividend: 2^48 for 1/r, or |d| << 24 for the unit vector
    always_comb
    begin
        case (uop_reg.num_sel)
            NUM_DX:
            begin
                div_num = {(dx_reg[31] ? (~dx_reg + 1'b1) : dx_reg), 24'd0};
                div_neg = dx_reg[31];
            end
            NUM_DY:
            begin
                div_num = {(dy_reg[31] ? (~dy_reg + 1'b1) : dy_reg), 24'd0};
                div_neg = dy_reg[31];
            end
            default:
            begin
                div_num = NUM_W'(1) << Q_W;
                div_neg = 1'b0;
            end
        endcase
    end

    // operands are taken from uop_reg in the cycle after the start command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_start <= 1'b0;
            div_start <= 1'b0;
        end
        else
        begin
            mul_start <= cmd.start && (cmd.uop.kind == K_MUL);
            div_start <= cmd.start && (cmd.uop.kind == K_DIV);
        end
    end

    pfa_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (opa),
        .b     (opb),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    pfa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .neg   (div_neg),
        .den   (root_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign unit_res = mul_done ? mul_prod : div_quo;

    // square root, two radicand bits per step
    assign sq_rem_sh = {sq_rem_reg[29:0], sq_n_reg[NUM_W-1:NUM_W-2]};
    assign sq_trial  = {2'b00, root_reg, 2'b01};
    assign sq_ge     = sq_rem_sh >= sq_trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_busy_reg <= 1'b0;
            sq_done_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end
        else
        begin
            sq_done_reg <= 1'b0;
            if (cmd.start && cmd.uop.kind == K_SQRT)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg  <= '0;
            end
            else if (sq_busy_reg)
            begin
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == SQ_LAST)
                begin
                    sq_busy_reg <= 1'b0;
                    sq_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && cmd.uop.kind == K_SQRT)
        begin
            sq_n_reg   <= {d2_reg, 24'd0};
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end
        else if (sq_busy_reg)
        begin
            sq_n_reg   <= {sq_n_reg[NUM_W-3:0], 2'b00};
            sq_rem_reg <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
            root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
        end
    end

    // item latch and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= item.operation;
            dx_reg  <= item.delta_x;
            dy_reg  <= item.delta_y;
            d2_reg  <= item.dist_sq;
            j_reg   <= item.first_index[ADDR_W-1:0];
            k_reg   <= item.second_index[ADDR_W-1:0];
            sum_reg <= '0;
        end
        else
        begin
            if (cmd.start)
                uop_reg <= cmd.uop;
            if (cmd.start && cmd.uop.kind == K_ADDC1)
                sum_reg <= sum_reg + SUM_W'(c1_reg);
            if (mul_done || div_done)
            begin
                case (uop_reg.dst)
                    DST_T0:  t0_reg  <= unit_res;
                    DST_T1:  t1_reg  <= unit_res;
                    DST_T2:  t2_reg  <= unit_res;
                    DST_SUM: sum_reg <= sum_reg + SUM_W'(unit_res);
                    DST_FX:  fx_reg  <= unit_res;
                    DST_FY:  fy_reg  <= unit_res;
                    default: ;
                endcase
            end
        end
    end

    // accumulator memory port control
    always_comb
    begin
        re    = 1'b0;
        we    = 1'b0;
        raddr = j_reg;
        waddr = j_reg;
        wdx   = '0;
        wdy   = '0;
        case (cmd.mem_cmd)
            MEM_RD_J:
                re = 1'b1;
            MEM_RD_K:
            begin
                re    = 1'b1;
                raddr = k_reg;
            end
            MEM_WR_J_ADD:
            begin
                we  = 1'b1;
                wdx = sat_q(SUM_W'(signed'(rdx_reg)) + SUM_W'(fx_reg));
                wdy = sat_q(SUM_W'(signed'(rdy_reg)) + SUM_W'(fy_reg));
            end
            MEM_WR_K_SUB:
            begin
                we    = 1'b1;
                waddr = k_reg;
                wdx   = sat_q(SUM_W'(signed'(rdx_reg)) - SUM_W'(fx_reg));
                wdy   = sat_q(SUM_W'(signed'(rdy_reg)) - SUM_W'(fy_reg));
            end
            MEM_WR_J_ZRO:
                we = 1'b1;
            MEM_CLR:
            begin
                we    = 1'b1;
                waddr = cmd.clr_addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_x[waddr] <= wdx;
            mem_y[waddr] <= wdy;
        end
        if (re)
        begin
            rdx_reg <= mem_x[raddr];
            rdy_reg <= mem_y[raddr];
        end
    end

    // result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.status <= cmd.emit_status;
            case (cmd.emit_status)
                ST_APPLIED:
                begin
                    result_reg.force_x <= fx_reg;
                    result_reg.force_y <= fy_reg;
                end
                ST_READOUT:
                begin
                    result_reg.force_x <= rdx_reg;
                    result_reg.force_y <= rdy_reg;
                end
                default:
                begin
                    result_reg.force_x <= '0;
                    result_reg.force_y <= '0;
                end
            endcase
        end
    end

    assign st.is_read   = (op_reg == OP_READ);
    assign st.skip      = (d2_reg == 32'd0) || (d2_reg > cut_reg);
    assign st.law       = law_reg;
    assign st.unit_done = mul_done | div_done | sq_done_reg;

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/pfa_ctrl.sv */
// ----------------------------------------------------------------------------
// pfa_ctrl
// Controller: memory clear after reset, item dispatch, micro-op sequencing
// and the accumulator read-modify-write steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_ctrl
    import pfa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t st,
    output ctrl_cmd_t       cmd,
    output logic            busy
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_ISSUE = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_RDJ   = 4'd5;
    localparam logic [3:0] S_WRJ   = 4'd6;
    localparam logic [3:0] S_RDK   = 4'd7;
    localparam logic [3:0] S_WRK   = 4'd8;
    localparam logic [3:0] S_RCLR  = 4'd9;

    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_PARTICLES - 1);

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] clr_next;
    uop_t              uop;

    assign uop = uop_rom(pc_reg);

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        clr_next        = clr_reg;
        cmd.load        = 1'b0;
        cmd.start       = 1'b0;
        cmd.uop         = uop;
        cmd.mem_cmd     = MEM_NONE;
        cmd.clr_addr    = clr_reg;
        cmd.emit        = 1'b0;
        cmd.emit_status = ST_APPLIED;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.mem_cmd = MEM_CLR;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                pc_next = '0;
                if (st.is_read)
                    state_next = S_RDJ;
                else if (st.skip)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_SKIPPED;
                    state_next      = S_IDLE;
                end
                else
                    state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                case (uop.kind)
                    K_SQRT, K_MUL, K_DIV:
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_WAIT;
                    end
                    K_ADDC1:
                    begin
                        cmd.start = 1'b1;
                        pc_next   = pc_reg + 1'b1;
                    end
                    K_BRANCH:
                        pc_next = law_pc(st.law);
                    K_TAIL:
                        pc_next = PC_TAIL;
                    default:
                        state_next = S_RDJ;
                endcase
            end
            S_WAIT:
            begin
                if (st.unit_done)
                begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = S_ISSUE;
                end
            end
            S_RDJ:
            begin
                cmd.mem_cmd = MEM_RD_J;
                state_next  = st.is_read ? S_RCLR : S_WRJ;
            end
            S_RCLR:
            begin
                cmd.mem_cmd     = MEM_WR_J_ZRO;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_READOUT;
                state_next      = S_IDLE;
            end
            S_WRJ:
            begin
                cmd.mem_cmd = MEM_WR_J_ADD;
                state_next  = S_RDK;
            end
            S_RDK:
            begin
                // read after the first write lands, so a repeated index sees it
                cmd.mem_cmd = MEM_RD_K;
                state_next  = S_WRK;
            end
            S_WRK:
            begin
                cmd.mem_cmd     = MEM_WR_K_SUB;
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_APPLIED;
                state_next      = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pc_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            clr_reg   <= clr_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/pair_force_accumulator.sv */
// ----------------------------------------------------------------------------
// pair_force_accumulator
// 2D short-range pair force evaluation with per-particle force accumulators.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; exactly one result beat
// follows on result with done high for one cycle, and it cannot be held off.
// After reset the accumulator memories are cleared, one entry per cycle, so
// busy stays high until the last entry is cleared. The next item can be
// taken at the end of the cycle in which a result beat shows up. An applied
// pair runs a 28-step square root, a 56-step divider (twice for the unit
// vector, once more for 1/r under WCA) and a serial 4-product multiplier,
// then the accumulator read-modify-write: a read and a write of the first
// index, then a read and a write of the second. Configuration writes are
// always accepted (cfg_ready is tied high) and must only be made while busy
// is low and no result is pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pair_force_accumulator
    import pfa_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire in_item_t       item,
    output out_item_t           result,
    output logic                done,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [Q_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t st;

    assign cfg_ready = 1'b1;

    pfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    pfa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .st        (st),
        .result    (result),
        .done      (done)
    );

endmodule

`default_nettype wire

/* hw/rtl/pfa_checker.sv */
// ----------------------------------------------------------------------------
// pfa_checker
// Port-level checks on the pair force accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfa_checker
    import pfa_pkg::*;
(
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire out_item_t      result,
    input wire logic           done
);

    // an accepted item holds the block off next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // one beat per item, never two in a row
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result beats");

    // a beat is only produced by work in progress
    a_beat_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without an item in flight");

    // skipped pairs carry zero force
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_SKIPPED |-> result.force_x == '0 &&
                                                result.force_y == '0)
        else $error("skipped pair with nonzero force");

endmodule

bind pair_force_accumulator pfa_checker u_pfa_checker (.*);

`default_nettype wire
